[rtl/writer_priority_rwlock_manager_core_assert.svh]
// assertion macros shared by the rwlock manager rtl
// depends on nothing; included by the top level only
`ifndef WRITER_PRIORITY_RWLOCK_MANAGER_CORE_ASSERT_SVH
`define WRITER_PRIORITY_RWLOCK_MANAGER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RWLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RWLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rwlm_pkg.sv]
// shared codes, defaults and types of the writer-priority rwlock manager
// no dependencies; imported by every rtl module of the block
package rwlm_pkg;

   localparam int DEF_QUEUE_DEPTH    = 16;
   localparam int DEF_THREAD_ID_BITS = 8;

   localparam int CMD_W    = 3;
   localparam int STATUS_W = 3;
   localparam int TID_W    = 8;
   localparam int READERS_W = 9;

   localparam logic [READERS_W-1:0] READER_MAX = 9'd511;

   // request commands
   localparam logic [CMD_W-1:0] CMD_RD_LOCK   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RD_TRY    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RD_UNLOCK = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WR_LOCK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WR_TRY    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_WR_UNLOCK = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_HOLDER = 3'd5;

   typedef struct packed {
      logic                 writer_active;
      logic [READERS_W-1:0] active_readers;
   } lock_status_type;

endpackage

[rtl/rwlm_ram.sv]
// one-write one-read synchronous ram for a wait queue, registered read data
// uses rwlm_pkg only for its parameter defaults
module rwlm_ram
   import rwlm_pkg::*;
#(
   parameter int DEPTH = DEF_QUEUE_DEPTH,
   parameter int WIDTH = DEF_THREAD_ID_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rwlm_ctrl.sv]
// lock state, queue pointers, request decode and result register
// depends on rwlm_pkg; drives the two queue rams instantiated at the top
module rwlm_ctrl
   import rwlm_pkg::*;
#(
   parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
   parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   // request
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [CMD_W-1:0]               req_cmd,
   input  logic [TID_W-1:0]               req_thread_id,
   // result
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic                           rsp_wake_valid,
   output logic [TID_W-1:0]               rsp_wake_thread,
   output logic                           rsp_wake_is_writer,
   output logic                           rsp_last,
   // reader queue ram
   output logic                           rq_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] rq_wr_addr,
   output logic [THREAD_ID_BITS-1:0]      rq_wr_data,
   output logic                           rq_rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] rq_rd_addr,
   input  logic [THREAD_ID_BITS-1:0]      rq_rd_data,
   // writer queue ram
   output logic                           wq_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] wq_wr_addr,
   output logic [THREAD_ID_BITS-1:0]      wq_wr_data,
   output logic                           wq_rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] wq_rd_addr,
   input  logic [THREAD_ID_BITS-1:0]      wq_rd_data,
   // lock status
   output lock_status_type                lock_status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int EXT_W = (THREAD_ID_BITS > TID_W) ? THREAD_ID_BITS : TID_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WAKE_W = 2'd1;
   localparam logic [1:0] S_WAKE_R = 2'd2;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      n = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
      return n;
   endfunction

   logic [1:0]           state_ff, state_in;
   logic [READERS_W-1:0] readers_ff, readers_in;
   logic                 writer_ff, writer_in;
   logic [CNT_W-1:0]     wcnt_ff, wcnt_in;
   logic [CNT_W-1:0]     rcnt_ff, rcnt_in;
   logic [PTR_W-1:0]     rd_head_ff, rd_head_in, rd_tail_ff, rd_tail_in;
   logic [PTR_W-1:0]     wr_head_ff, wr_head_in, wr_tail_ff, wr_tail_in;

   logic                 out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;
   logic                 out_wv_ff, out_wv_in;
   logic [TID_W-1:0]     out_tid_ff, out_tid_in;
   logic                 out_isw_ff, out_isw_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_load;

   logic                 out_free;
   logic                 accept;
   logic                 read_ok, write_ok, rd_sat;
   logic [EXT_W-1:0]     req_tid_ext, rq_ext, wq_ext;
   logic [PTR_W-1:0]     rd_head_next;

   assign out_free    = !out_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == S_IDLE) && out_free;
   assign accept      = req_valid && req_ready;
   assign read_ok     = !writer_ff && (wcnt_ff == '0);
   assign write_ok    = (readers_ff == '0) && !writer_ff;
   assign rd_sat      = (readers_ff == READER_MAX);
   assign req_tid_ext = EXT_W'(req_thread_id);
   assign rq_ext      = EXT_W'(rq_rd_data);
   assign wq_ext      = EXT_W'(wq_rd_data);
   assign rd_head_next = next_slot(rd_head_ff);

   assign rq_wr_addr = rd_tail_ff;
   assign rq_wr_data = req_tid_ext[THREAD_ID_BITS-1:0];
   assign wq_wr_addr = wr_tail_ff;
   assign wq_wr_data = req_tid_ext[THREAD_ID_BITS-1:0];
   assign wq_rd_addr = wr_head_ff;

   always_comb begin
      state_in    = state_ff;
      readers_in  = readers_ff;
      writer_in   = writer_ff;
      wcnt_in     = wcnt_ff;
      rcnt_in     = rcnt_ff;
      rd_head_in  = rd_head_ff;
      rd_tail_in  = rd_tail_ff;
      wr_head_in  = wr_head_ff;
      wr_tail_in  = wr_tail_ff;
      out_load    = 1'b0;
      out_status_in = ST_BUSY;
      out_wv_in   = 1'b0;
      out_tid_in  = '0;
      out_isw_in  = 1'b0;
      out_last_in = 1'b1;
      rq_wr_en    = 1'b0;
      wq_wr_en    = 1'b0;
      rq_rd_en    = 1'b0;
      rq_rd_addr  = rd_head_ff;
      wq_rd_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               out_load = 1'b1;
               unique case (req_cmd)
                  CMD_RD_LOCK: begin
                     if (read_ok) begin
                        if (rd_sat) begin
                           out_status_in = ST_BUSY;
                        end else begin
                           readers_in    = readers_ff + 9'd1;
                           out_status_in = ST_GRANTED;
                        end
                     end else if (rcnt_ff == CNT_FULL) begin
                        out_status_in = ST_FULL;
                     end else begin
                        rq_wr_en      = 1'b1;
                        rd_tail_in    = next_slot(rd_tail_ff);
                        rcnt_in       = rcnt_ff + CNT_W'(1);
                        out_status_in = ST_QUEUED;
                     end
                  end
                  CMD_RD_TRY: begin
                     if (read_ok && !rd_sat) begin
                        readers_in    = readers_ff + 9'd1;
                        out_status_in = ST_GRANTED;
                     end else begin
                        out_status_in = ST_BUSY;
                     end
                  end
                  CMD_RD_UNLOCK: begin
                     if (readers_ff == '0) begin
                        out_status_in = ST_NO_HOLDER;
                     end else begin
                        readers_in = readers_ff - 9'd1;
                        if ((readers_ff == 9'd1) && (wcnt_ff != '0)) begin
                           // last reader out: hand the lock to the oldest writer
                           writer_in = 1'b1;
                           wq_rd_en  = 1'b1;
                           out_load  = 1'b0;
                           state_in  = S_WAKE_W;
                        end else begin
                           out_status_in = ST_RELEASED;
                        end
                     end
                  end
                  CMD_WR_LOCK: begin
                     if (write_ok) begin
                        writer_in     = 1'b1;
                        out_status_in = ST_GRANTED;
                     end else if (wcnt_ff == CNT_FULL) begin
                        out_status_in = ST_FULL;
                     end else begin
                        wq_wr_en      = 1'b1;
                        wr_tail_in    = next_slot(wr_tail_ff);
                        wcnt_in       = wcnt_ff + CNT_W'(1);
                        out_status_in = ST_QUEUED;
                     end
                  end
                  CMD_WR_TRY: begin
                     if (write_ok) begin
                        writer_in     = 1'b1;
                        out_status_in = ST_GRANTED;
                     end else begin
                        out_status_in = ST_BUSY;
                     end
                  end
                  CMD_WR_UNLOCK: begin
                     if (!writer_ff) begin
                        out_status_in = ST_NO_HOLDER;
                     end else if (wcnt_ff != '0) begin
                        // writer stays active, ownership passes on
                        wq_rd_en = 1'b1;
                        out_load = 1'b0;
                        state_in = S_WAKE_W;
                     end else if ((rcnt_ff == '0) || rd_sat) begin
                        writer_in     = 1'b0;
                        out_status_in = ST_RELEASED;
                     end else begin
                        writer_in = 1'b0;
                        rq_rd_en  = 1'b1;
                        out_load  = 1'b0;
                        state_in  = S_WAKE_R;
                     end
                  end
                  default: begin
                     out_status_in = ST_BUSY;
                  end
               endcase
            end
         end
         S_WAKE_W: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_status_in = ST_RELEASED;
               out_wv_in     = 1'b1;
               out_tid_in    = wq_ext[TID_W-1:0];
               out_isw_in    = 1'b1;
               wr_head_in    = next_slot(wr_head_ff);
               wcnt_in       = wcnt_ff - CNT_W'(1);
               state_in      = S_IDLE;
            end
         end
         S_WAKE_R: begin
            // one woken reader per cycle while the result register is free, next head read issued alongside
            if (out_free) begin
               out_load      = 1'b1;
               out_status_in = ST_RELEASED;
               out_wv_in     = 1'b1;
               out_tid_in    = rq_ext[TID_W-1:0];
               out_last_in   = (rcnt_ff == CNT_W'(1)) ||
                               (readers_ff == READER_MAX - 9'd1);
               rd_head_in    = rd_head_next;
               rcnt_in       = rcnt_ff - CNT_W'(1);
               readers_in    = readers_ff + 9'd1;
               if (out_last_in) begin
                  state_in = S_IDLE;
               end else begin
                  rq_rd_en   = 1'b1;
                  rq_rd_addr = rd_head_next;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         readers_ff   <= '0;
         writer_ff    <= 1'b0;
         wcnt_ff      <= '0;
         rcnt_ff      <= '0;
         rd_head_ff   <= '0;
         rd_tail_ff   <= '0;
         wr_head_ff   <= '0;
         wr_tail_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         readers_ff   <= readers_in;
         writer_ff    <= writer_in;
         wcnt_ff      <= wcnt_in;
         rcnt_ff      <= rcnt_in;
         rd_head_ff   <= rd_head_in;
         rd_tail_ff   <= rd_tail_in;
         wr_head_ff   <= wr_head_in;
         wr_tail_ff   <= wr_tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_status_ff <= out_status_in;
         out_wv_ff     <= out_wv_in;
         out_tid_ff    <= out_tid_in;
         out_isw_ff    <= out_isw_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_wake_valid     = out_wv_ff;
   assign rsp_wake_thread    = out_tid_ff;
   assign rsp_wake_is_writer = out_isw_ff;
   assign rsp_last           = out_last_ff;

   assign lock_status.writer_active  = writer_ff;
   assign lock_status.active_readers = readers_ff;

endmodule

[rtl/writer_priority_rwlock_manager_core.sv]
// Writer-priority reader-writer lock manager. Each request item carries a command and a
// thread id; readers share the lock while no writer holds or waits, writers get it alone,
// and waiting threads sit in two queue rams (reader and writer) until the lock is handed
// to them. Results: most requests give their single result in the cycle after acceptance;
// a handoff to a waiting writer first reads the writer queue ram, then registers its result;
// a write unlock that wakes queued readers reads the reader queue ram and then wakes one
// reader a cycle while the result register is free. One request is in flight at a time
// and a new one is taken only when the result register is empty or is read out that cycle.
// Queue rams need no clearing after reset: only written entries are ever read.
// depends on rwlm_pkg, rwlm_ram, rwlm_ctrl and the assertion macro header
`include "writer_priority_rwlock_manager_core_assert.svh"

module writer_priority_rwlock_manager_core
   import rwlm_pkg::*;
#(
   parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH,
   parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // cmd[2:0], thread_id[10:3], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[2:0], wake_valid[3], wake_thread[11:4],
                                    // wake_is_writer[12], zero fill
   output logic        rsp_tlast
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [STATUS_W-1:0]       status;
   logic                      wake_valid;
   logic [TID_W-1:0]          wake_thread;
   logic                      wake_is_writer;
   lock_status_type           lock_status;

   logic                      rq_wr_en, rq_rd_en, wq_wr_en, wq_rd_en;
   logic [PTR_W-1:0]          rq_wr_addr, rq_rd_addr, wq_wr_addr, wq_rd_addr;
   logic [THREAD_ID_BITS-1:0] rq_wr_data, rq_rd_data, wq_wr_data, wq_rd_data;

   rwlm_ctrl #(
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .THREAD_ID_BITS (THREAD_ID_BITS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_tvalid),
      .req_ready          (req_tready),
      .req_cmd            (req_tdata[2:0]),
      .req_thread_id      (req_tdata[10:3]),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_status         (status),
      .rsp_wake_valid     (wake_valid),
      .rsp_wake_thread    (wake_thread),
      .rsp_wake_is_writer (wake_is_writer),
      .rsp_last           (rsp_tlast),
      .rq_wr_en           (rq_wr_en),
      .rq_wr_addr         (rq_wr_addr),
      .rq_wr_data         (rq_wr_data),
      .rq_rd_en           (rq_rd_en),
      .rq_rd_addr         (rq_rd_addr),
      .rq_rd_data         (rq_rd_data),
      .wq_wr_en           (wq_wr_en),
      .wq_wr_addr         (wq_wr_addr),
      .wq_wr_data         (wq_wr_data),
      .wq_rd_en           (wq_rd_en),
      .wq_rd_addr         (wq_rd_addr),
      .wq_rd_data         (wq_rd_data),
      .lock_status        (lock_status)
   );

   rwlm_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (THREAD_ID_BITS)
   ) u_reader_q (
      .clock   (clock),
      .wr_en   (rq_wr_en),
      .wr_addr (rq_wr_addr),
      .wr_data (rq_wr_data),
      .rd_en   (rq_rd_en),
      .rd_addr (rq_rd_addr),
      .rd_data (rq_rd_data)
   );

   rwlm_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (THREAD_ID_BITS)
   ) u_writer_q (
      .clock   (clock),
      .wr_en   (wq_wr_en),
      .wr_addr (wq_wr_addr),
      .wr_data (wq_wr_data),
      .rd_en   (wq_rd_en),
      .rd_addr (wq_rd_addr),
      .rd_data (wq_rd_data)
   );

   assign rsp_tdata = {3'b000, wake_is_writer, wake_thread, wake_valid, status};

   // a writer never shares the lock with readers
   `RWLM_ASSERT_NOW(a_excl, clock, reset,
      lock_status.writer_active, lock_status.active_readers == '0,
      "writer active while readers hold the lock")

   // a writer wake leaves that writer holding the lock
   `RWLM_ASSERT_NOW(a_wake_writer, clock, reset,
      rsp_tvalid && wake_valid && wake_is_writer, lock_status.writer_active,
      "woken writer does not hold the lock")

   // a reader wake is counted among the holders
   `RWLM_ASSERT_NOW(a_wake_reader, clock, reset,
      rsp_tvalid && wake_valid && !wake_is_writer, lock_status.active_readers != '0,
      "woken reader not counted")

endmodule
